>>> rtl/oas_pkg.sv
// Package for the overlap alignment scorer.
// Holds action codes, register indexes, controller states and the
// command and status structs shared by controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
package oas_pkg;

	// Stored score width and internal calculation width
	localparam int SW = 14;
	localparam int CW = 16;
	localparam logic signed [CW-1:0] SCORE_MIN = -16'sd8192;
	localparam logic signed [CW-1:0] SCORE_MAX = 16'sd8191;

	// Input actions
	localparam logic [1:0] ACT_LOAD1   = 2'd0;
	localparam logic [1:0] ACT_LOAD2   = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MATCH   = 2'd0;
	localparam logic [1:0] CFG_REPLACE = 2'd1;
	localparam logic [1:0] CFG_INDEL   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_CELL_RD,
		ST_CELL_WR,
		ST_SC_INIT,
		ST_SC_BEST,
		ST_COL_RD,
		ST_COL_CMP,
		ST_SROW_RD,
		ST_SROW_CMP,
		ST_TB_INIT,
		ST_TB_CHK,
		ST_TB_RH,
		ST_TB_RL,
		ST_TB_RU,
		ST_TB_STEP,
		ST_DONE,
		ST_DONE_ERR
	} oas_state_t;

	// Score matrix read address select
	typedef enum logic [2:0] {
		MA_UP,
		MA_END,
		MA_COLI,
		MA_ROWI,
		MA_HERE,
		MA_LEFT,
		MA_ABOVE
	} oas_maddr_t;

	typedef struct packed {
		logic       accept;
		logic       fill_init;
		logic       row_rd;
		logic       cell_rd;
		logic       cell_wr;
		logic       mre;
		oas_maddr_t msel;
		logic       best_init;
		logic       col_cmp;
		logic       srow_init;
		logic       row_cmp;
		logic       tb_init;
		logic       tb_here;
		logic       tb_left;
		logic       tb_step;
		logic       out_load;
		logic       out_empty;
	} oas_cmd_t;

	typedef struct packed {
		logic n_empty;
		logic c_last;
		logic r_last;
		logic col_last;
		logic row_last;
		logic tb_stop;
		logic out_free;
	} oas_status_t;

endpackage
`default_nettype wire

>>> rtl/overlap_alignment_scorer.sv
// Overlap alignment scorer: load items, cell matrix walk and result.
// Instantiates oas_ctrl and oas_datapath; uses oas_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready, action, symbol): load first or second
//   sequence symbol, compute, or clear. Loads and clears give no result;
//   a load to a full sequence is dropped.
// - Compute reads the first-sequence symbol for each row (ROW_RD), fills
//   the score matrix with a read and a write state per cell (one matrix
//   read port), sets up the end search (SC_INIT, SC_BEST), reads and
//   compares each cell of the last column and last row, starts the
//   traceback (TB_INIT), runs each traceback step as a stop check, reads
//   of the cell and its left and upper neighbours and a move, and ends on
//   a final stop check; with an empty sequence it loads an error result.
// - in_ready is high only while no compute is in progress.
// - Output channel (out_valid/out_ready) carries one result per compute,
//   held in a result register; a stalled receiver holds the block in its
//   final state until the register frees.
// - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while idle.
// - Reset clears lengths and sets all three scores to 1. Symbol and matrix
//   stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module overlap_alignment_scorer #(
	parameter int MAX_LEN = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  action,
	input  wire logic [7:0]                  symbol,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [3:0]                  cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [oas_pkg::SW-1:0]    best_score,
	output logic [$clog2(MAX_LEN+1)-1:0]     end_first,
	output logic [$clog2(MAX_LEN+1)-1:0]     end_second,
	output logic [$clog2(MAX_LEN+1)-1:0]     start_first,
	output logic [$clog2(MAX_LEN+1)-1:0]     start_second,
	output logic                             ends_on_last_row,
	output logic                             empty_error
);
	import oas_pkg::*;

	oas_cmd_t cmd;
	oas_status_t sts;

	assign cfg_ready = 1'b1;

	oas_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .sts(sts), .cmd(cmd)
	);

	oas_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.action(action), .symbol(symbol),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_score(best_score), .end_first(end_first), .end_second(end_second),
		.start_first(start_first), .start_second(start_second),
		.ends_on_last_row(ends_on_last_row), .empty_error(empty_error)
	);
endmodule
`default_nettype wire

>>> rtl/oas_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module oas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; read data holds when not reading
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/oas_ctrl.sv
// Controller state machine for the overlap alignment scorer.
// Depends on oas_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps
`default_nettype none
module oas_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          action,
	input  wire oas_pkg::oas_status_t sts,
	output oas_pkg::oas_cmd_t        cmd
);
	import oas_pkg::*;

	oas_state_t state_q, state_d;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_COMPUTE) begin
					state_d = sts.n_empty ? ST_DONE_ERR : ST_ROW_RD;
				end
			end
			ST_ROW_RD:  state_d = ST_CELL_RD;
			ST_CELL_RD: state_d = ST_CELL_WR;
			ST_CELL_WR: begin
				if (!sts.c_last) begin
					state_d = ST_CELL_RD;
				end else if (sts.r_last) begin
					state_d = ST_SC_INIT;
				end else begin
					state_d = ST_ROW_RD;
				end
			end
			ST_SC_INIT: state_d = ST_SC_BEST;
			ST_SC_BEST: state_d = ST_COL_RD;
			ST_COL_RD:  state_d = ST_COL_CMP;
			ST_COL_CMP: state_d = sts.col_last ? ST_SROW_RD : ST_COL_RD;
			ST_SROW_RD: state_d = ST_SROW_CMP;
			ST_SROW_CMP: state_d = sts.row_last ? ST_TB_INIT : ST_SROW_RD;
			ST_TB_INIT: state_d = ST_TB_CHK;
			ST_TB_CHK:  state_d = sts.tb_stop ? ST_DONE : ST_TB_RH;
			ST_TB_RH:   state_d = ST_TB_RL;
			ST_TB_RL:   state_d = ST_TB_RU;
			ST_TB_RU:   state_d = ST_TB_STEP;
			ST_TB_STEP: state_d = ST_TB_CHK;
			ST_DONE, ST_DONE_ERR: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.msel = MA_UP;
		cmd.accept = accept;
		unique case (state_q)
			ST_IDLE:    cmd.fill_init = accept && action == ACT_COMPUTE;
			ST_ROW_RD:  cmd.row_rd = 1'b1;
			ST_CELL_RD: begin
				cmd.cell_rd = 1'b1;
				cmd.mre = 1'b1;
				cmd.msel = MA_UP;
			end
			ST_CELL_WR: cmd.cell_wr = 1'b1;
			ST_SC_INIT: begin
				cmd.mre = 1'b1;
				cmd.msel = MA_END;
			end
			ST_SC_BEST: cmd.best_init = 1'b1;
			ST_COL_RD: begin
				cmd.mre = 1'b1;
				cmd.msel = MA_COLI;
			end
			ST_COL_CMP: begin
				cmd.col_cmp = 1'b1;
				cmd.srow_init = sts.col_last;
			end
			ST_SROW_RD: begin
				cmd.mre = 1'b1;
				cmd.msel = MA_ROWI;
			end
			ST_SROW_CMP: cmd.row_cmp = 1'b1;
			ST_TB_INIT:  cmd.tb_init = 1'b1;
			ST_TB_CHK:   cmd.tb_init = 1'b0;
			ST_TB_RH: begin
				cmd.mre = 1'b1;
				cmd.msel = MA_HERE;
			end
			ST_TB_RL: begin
				cmd.tb_here = 1'b1;
				cmd.mre = 1'b1;
				cmd.msel = MA_LEFT;
			end
			ST_TB_RU: begin
				cmd.tb_left = 1'b1;
				cmd.mre = 1'b1;
				cmd.msel = MA_ABOVE;
			end
			ST_TB_STEP: cmd.tb_step = 1'b1;
			ST_DONE:    cmd.out_load = sts.out_free;
			ST_DONE_ERR: begin
				cmd.out_load = sts.out_free;
				cmd.out_empty = 1'b1;
			end
			default: cmd.out_empty = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/oas_datapath.sv
// Datapath for the overlap alignment scorer: symbol stores, score matrix,
// cell update, end search, traceback and result register. Uses oas_pkg, oas_ram.
`timescale 1ns / 1ps
`default_nettype none
module oas_datapath #(
	parameter int MAX_LEN = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire oas_pkg::oas_cmd_t                   cmd,
	output oas_pkg::oas_status_t                     sts,
	input  wire logic [1:0]                          action,
	input  wire logic [7:0]                          symbol,
	input  wire logic                                cfg_valid,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [3:0]                          cfg_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [oas_pkg::SW-1:0]            best_score,
	output logic [$clog2(MAX_LEN+1)-1:0]             end_first,
	output logic [$clog2(MAX_LEN+1)-1:0]             end_second,
	output logic [$clog2(MAX_LEN+1)-1:0]             start_first,
	output logic [$clog2(MAX_LEN+1)-1:0]             start_second,
	output logic                                     ends_on_last_row,
	output logic                                     empty_error
);
	import oas_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int MW = 2 * LW;
	localparam logic [LW-1:0] ONE = LW'(1);

	logic [3:0] match_q, replace_q, indel_q;
	logic [LW-1:0] n1_q, n2_q, r_q, c_q, i_q, er_q, ec_q, sr_q, sc_q;
	logic signed [SW-1:0] best_q, here_q, lft_q;
	logic signed [CW-1:0] left_q, diag_q;
	logic [7:0] sym1, sym2;
	logic signed [SW-1:0] mrdata;
	logic [MW-1:0] mraddr;
	logic signed [CW-1:0] up_v, left_v, diag_v, max_v, cell_v, ind_v;
	logic load1, load2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 4'd1;
			replace_q <= 4'd1;
			indel_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MATCH:   match_q <= cfg_data;
				CFG_REPLACE: replace_q <= cfg_data;
				CFG_INDEL:   indel_q <= cfg_data;
				default:     match_q <= match_q;
			endcase
		end
	end

	// Sequence lengths: advance on load, drop on clear
	assign load1 = cmd.accept && action == ACT_LOAD1 && n1_q < LW'(MAX_LEN);
	assign load2 = cmd.accept && action == ACT_LOAD2 && n2_q < LW'(MAX_LEN);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q <= '0;
			n2_q <= '0;
		end else if (cmd.accept && action == ACT_CLEAR) begin
			n1_q <= '0;
			n2_q <= '0;
		end else begin
			if (load1) n1_q <= n1_q + ONE;
			if (load2) n2_q <= n2_q + ONE;
		end
	end

	oas_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_sym1 (
		.clk(clk), .we(load1), .waddr(n1_q[AW-1:0]), .wdata(symbol),
		.re(cmd.row_rd), .raddr(AW'(r_q - ONE)), .rdata(sym1)
	);
	oas_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_sym2 (
		.clk(clk), .we(load2), .waddr(n2_q[AW-1:0]), .wdata(symbol),
		.re(cmd.cell_rd), .raddr(AW'(c_q - ONE)), .rdata(sym2)
	);

	// Matrix read address select
	always_comb begin
		unique case (cmd.msel)
			MA_UP:    mraddr = {r_q - ONE, c_q};
			MA_END:   mraddr = {n1_q, n2_q};
			MA_COLI:  mraddr = {i_q, n2_q};
			MA_ROWI:  mraddr = {n1_q, i_q};
			MA_HERE:  mraddr = {sr_q, sc_q};
			MA_LEFT:  mraddr = {sr_q, sc_q - ONE};
			MA_ABOVE: mraddr = {sr_q - ONE, sc_q};
			default:  mraddr = {r_q, c_q};
		endcase
	end

	oas_ram #(.WIDTH(SW), .DEPTH(1 << MW)) u_mat (
		.clk(clk), .we(cmd.cell_wr), .waddr({r_q, c_q}), .wdata(SW'(cell_v)),
		.re(cmd.mre), .raddr(mraddr), .rdata(mrdata)
	);

	// Cell update: row 0 and column 0 read as zero
	assign ind_v = CW'(indel_q);
	always_comb begin
		up_v = (r_q == ONE) ? '0 : CW'(mrdata);
		left_v = (c_q == ONE) ? '0 : left_q;
		diag_v = (c_q == ONE) ? '0 : diag_q;
		if (sym1 == sym2) begin
			diag_v = diag_v + CW'(match_q);
		end else begin
			diag_v = diag_v - CW'(replace_q);
		end
		max_v = up_v - ind_v;
		if (left_v - ind_v > max_v) max_v = left_v - ind_v;
		if (diag_v > max_v) max_v = diag_v;
		if (max_v < SCORE_MIN) begin
			cell_v = SCORE_MIN;
		end else if (max_v > SCORE_MAX) begin
			cell_v = SCORE_MAX;
		end else begin
			cell_v = max_v;
		end
	end

	// Walk, end search and traceback registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			i_q <= '0;
			er_q <= '0;
			ec_q <= '0;
			sr_q <= '0;
			sc_q <= '0;
		end else begin
			if (cmd.fill_init) begin
				r_q <= ONE;
				c_q <= ONE;
			end else if (cmd.cell_wr) begin
				if (c_q == n2_q) begin
					c_q <= ONE;
					r_q <= r_q + ONE;
				end else begin
					c_q <= c_q + ONE;
				end
			end
			if (cmd.best_init) begin
				er_q <= n1_q;
				ec_q <= n2_q;
				i_q <= ONE;
			end else if (cmd.col_cmp) begin
				if (mrdata > best_q) er_q <= i_q;
				i_q <= cmd.srow_init ? ONE : i_q + ONE;
			end else if (cmd.row_cmp) begin
				if (mrdata > best_q) begin
					ec_q <= i_q;
					er_q <= n1_q;
				end
				i_q <= i_q + ONE;
			end
			if (cmd.tb_init) begin
				sr_q <= er_q;
				sc_q <= ec_q;
			end else if (cmd.tb_step) begin
				if (CW'(lft_q) - ind_v == CW'(here_q)) begin
					sc_q <= sc_q - ONE;
				end else if (CW'(mrdata) - ind_v == CW'(here_q)) begin
					sr_q <= sr_q - ONE;
				end else begin
					sr_q <= sr_q - ONE;
					sc_q <= sc_q - ONE;
				end
			end
		end
	end

	// Score payload registers
	always_ff @(posedge clk) begin
		if (cmd.cell_wr) begin
			left_q <= cell_v;
			diag_q <= up_v;
		end
		if (cmd.best_init || ((cmd.col_cmp || cmd.row_cmp) && mrdata > best_q)) begin
			best_q <= mrdata;
		end
		if (cmd.tb_here) here_q <= mrdata;
		if (cmd.tb_left) lft_q <= mrdata;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_empty) begin
				best_score <= '0;
				end_first <= '0;
				end_second <= '0;
				start_first <= '0;
				start_second <= '0;
				ends_on_last_row <= 1'b0;
				empty_error <= 1'b1;
			end else begin
				best_score <= best_q;
				end_first <= er_q;
				end_second <= ec_q;
				start_first <= sr_q;
				start_second <= sc_q;
				ends_on_last_row <= (er_q == n1_q);
				empty_error <= 1'b0;
			end
		end
	end

	// Status
	assign sts.n_empty = (n1_q == '0) || (n2_q == '0);
	assign sts.c_last = (c_q == n2_q);
	assign sts.r_last = (r_q == n1_q);
	assign sts.col_last = (i_q == n1_q);
	assign sts.row_last = (i_q == n2_q);
	assign sts.tb_stop = (sr_q == ONE) || (sc_q == ONE);
	assign sts.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for overlap_alignment_scorer.
// Drives load, clear and compute items, predicts each result in the bench
// and compares against the output channel; depends on rtl/oas_pkg.sv.
`timescale 1ns / 1ps
module testbench;
	import oas_pkg::*;

	localparam int SEQ_MAX = 256;
	localparam int LIMIT = 3000000;

	typedef struct {
		logic [1:0] act;
		logic [7:0] sym;
	} align_item_t;

	typedef struct {
		logic signed [13:0] score;
		logic [8:0]         end_r;
		logic [8:0]         end_c;
		logic [8:0]         start_r;
		logic [8:0]         start_c;
		logic               last_row;
		logic               err;
	} align_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic [1:0] action = ACT_CLEAR;
	logic [7:0] symbol = 0;
	logic cfg_valid = 0;
	logic [1:0] cfg_index = CFG_MATCH;
	logic [3:0] cfg_data = 0;
	logic out_ready = 0;
	wire in_ready, cfg_ready, out_valid, ends_on_last_row, empty_error;
	wire signed [13:0] best_score;
	wire [8:0] end_first, end_second, start_first, start_second;

	overlap_alignment_scorer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .symbol(symbol),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .best_score(best_score),
		.end_first(end_first), .end_second(end_second), .start_first(start_first),
		.start_second(start_second), .ends_on_last_row(ends_on_last_row),
		.empty_error(empty_error)
	);

	always #10 clk = ~clk;

	// bench copy of the block state
	logic [7:0] seq_a [0:SEQ_MAX-1];
	logic [7:0] seq_b [0:SEQ_MAX-1];
	int len_a = 0, len_b = 0;
	int gain_match = 1, cost_replace = 1, cost_indel = 1;
	int grid [0:SEQ_MAX][0:SEQ_MAX];

	align_item_t pending_items[$];
	align_result_t expected_alignments[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit in_taken = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
			want);
		fail_count++;
	endtask

	// work out the alignment for one item and queue the result
	task automatic predict_alignment(input logic [1:0] act, input logic [7:0] sym);
		align_result_t r;
		int up, left, diag, best, er, ec, sr, sc;
		r = '{default: 0};
		case (act)
			ACT_LOAD1: begin
				if (len_a < SEQ_MAX) begin
					seq_a[len_a] = sym;
					len_a++;
				end
			end
			ACT_LOAD2: begin
				if (len_b < SEQ_MAX) begin
					seq_b[len_b] = sym;
					len_b++;
				end
			end
			ACT_CLEAR: begin
				len_a = 0;
				len_b = 0;
			end
			default: begin
				if (len_a == 0 || len_b == 0) begin
					r.err = 1;
				end else begin
					for (int c = 0; c <= len_b; c++) grid[0][c] = 0;
					for (int i = 1; i <= len_a; i++) begin
						grid[i][0] = 0;
						for (int c = 1; c <= len_b; c++) begin
							up = grid[i-1][c] - cost_indel;
							left = grid[i][c-1] - cost_indel;
							diag = grid[i-1][c-1] +
								((seq_a[i-1] == seq_b[c-1]) ? gain_match : -cost_replace);
							best = up;
							if (left > best) best = left;
							if (diag > best) best = diag;
							if (best > 8191) best = 8191;
							if (best < -8192) best = -8192;
							grid[i][c] = best;
						end
					end
					er = len_a;
					ec = len_b;
					for (int i = 1; i <= len_a; i++)
						if (grid[i][len_b] > grid[er][ec]) er = i;
					for (int i = 1; i <= len_b; i++)
						if (grid[len_a][i] > grid[er][ec]) begin
							ec = i;
							er = len_a;
						end
					sr = er;
					sc = ec;
					while (sr != 1 && sc != 1) begin
						if (grid[sr][sc-1] - cost_indel == grid[sr][sc]) sc--;
						else if (grid[sr-1][sc] - cost_indel == grid[sr][sc]) sr--;
						else begin
							sr--;
							sc--;
						end
					end
					r.score = 14'(grid[er][ec]);
					r.end_r = 9'(er);
					r.end_c = 9'(ec);
					r.start_r = 9'(sr);
					r.start_c = 9'(sc);
					r.last_row = (er == len_a);
				end
				expected_alignments.insert(expected_alignments.size(), r);
			end
		endcase
	endtask

	// sample accepted items, config writes and results
	always @(posedge clk) begin
		align_result_t e;
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			in_taken = in_valid && in_ready;
			if (in_taken) predict_alignment(action, symbol);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MATCH: gain_match = cfg_data;
					CFG_REPLACE: cost_replace = cfg_data;
					CFG_INDEL: cost_indel = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_alignments.size() == 0) begin
					report("unexpected result, score", best_score, 0);
				end else begin
					e = expected_alignments.pop_front();
					if (best_score !== e.score) report("best_score", best_score, e.score);
					if (end_first !== e.end_r) report("end_first", end_first, e.end_r);
					if (end_second !== e.end_c) report("end_second", end_second, e.end_c);
					if (start_first !== e.start_r)
						report("start_first", start_first, e.start_r);
					if (start_second !== e.start_c)
						report("start_second", start_second, e.start_c);
					if (ends_on_last_row !== e.last_row)
						report("ends_on_last_row", ends_on_last_row, e.last_row);
					if (empty_error !== e.err) report("empty_error", empty_error, e.err);
				end
			end
		end
	end

	// drive items in bursts with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		align_item_t it;
		if (arst_n && (in_taken || !in_valid)) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				burst_left--;
				action <= it.act;
				symbol <= it.sym;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// stall the result side in changing patterns
	int stall_mode = 0;
	always @(negedge clk) begin
		if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic add_item(input logic [1:0] act, input logic [7:0] sym);
		pending_items.insert(pending_items.size(), '{act, sym});
	endtask

	function automatic logic [7:0] pick_symbol();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_scores(input int m, input int rp, input int ind);
		write_reg(CFG_MATCH, 4'(m));
		write_reg(CFG_REPLACE, 4'(rp));
		write_reg(CFG_INDEL, 4'(ind));
	endtask

	// hold until the block has drained every item and result
	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid && expected_alignments.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	// one random alignment job, or some noise
	task automatic random_job();
		int na, nb, ia, ib;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) add_item(2'($urandom), 8'($urandom));
		end else begin
			if ($urandom_range(0, 9) != 0) add_item(ACT_CLEAR, 8'($urandom));
			na = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
			nb = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 29) == 0) na = $urandom_range(30, 48);
			ia = 0;
			ib = 0;
			while (ia < na || ib < nb) begin
				if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
					add_item(ACT_LOAD1, pick_symbol());
					ia++;
				end else begin
					add_item(ACT_LOAD2, pick_symbol());
					ib++;
				end
			end
			add_item(ACT_COMPUTE, 8'($urandom));
			if ($urandom_range(0, 4) == 0) add_item(ACT_COMPUTE, 8'($urandom));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: empty sequences, extreme symbols, repeat compute, clear
		add_item(ACT_COMPUTE, 8'h00);
		add_item(ACT_LOAD1, 8'h00);
		add_item(ACT_COMPUTE, 8'hff);
		add_item(ACT_CLEAR, 8'h00);
		add_item(ACT_LOAD2, 8'hff);
		add_item(ACT_COMPUTE, 8'h00);
		add_item(ACT_LOAD1, 8'hff);
		add_item(ACT_LOAD1, 8'h00);
		add_item(ACT_LOAD1, 8'haa);
		add_item(ACT_LOAD2, 8'h00);
		add_item(ACT_LOAD2, 8'h55);
		add_item(ACT_COMPUTE, 8'h00);
		add_item(ACT_COMPUTE, 8'hff);
		add_item(ACT_CLEAR, 8'hff);
		add_item(ACT_COMPUTE, 8'h00);
		drain();

		// extreme settings, with full sequences and dropped loads
		set_scores(0, 0, 0);
		repeat (3) add_item(ACT_LOAD1, pick_symbol());
		repeat (4) add_item(ACT_LOAD2, pick_symbol());
		add_item(ACT_COMPUTE, 0);
		drain();
		set_scores(15, 15, 15);
		add_item(ACT_CLEAR, 0);
		repeat (SEQ_MAX + 2) add_item(ACT_LOAD1, pick_symbol());
		repeat (5) add_item(ACT_LOAD2, pick_symbol());
		add_item(ACT_COMPUTE, 0);
		add_item(ACT_CLEAR, 0);
		repeat (SEQ_MAX) add_item(ACT_LOAD1, pick_symbol());
		repeat (SEQ_MAX + 1) add_item(ACT_LOAD2, pick_symbol());
		add_item(ACT_COMPUTE, 0);
		drain();
		set_scores(15, 0, 0);
		add_item(ACT_COMPUTE, 0);
		drain();

		// random jobs under several random settings
		for (int ph = 0; ph < 5; ph++) begin
			set_scores($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
			while (pending_items.size() < 250) random_job();
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
